// ===== rtl/core/tcac_pkg.sv =====
// Shared types and constants for the tree cell acceptance classifier.
// No dependencies; every other file of the block imports this package.
package tcac_pkg;

   // Field widths fixed by the item formats
   localparam int COORD_BITS  = 32;
   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int MAG_W       = COORD_BITS;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int DR2_W       = SQ_W + 2;
   localparam int RADIUS_W    = 31;
   localparam int RB_W        = RADIUS_W + 1;
   localparam int RB2_W       = 2 * RB_W;
   localparam int RC2_W       = 2 * RADIUS_W;
   localparam int MASS_W      = 32;
   localparam int DAUGHTER_W  = 21;
   localparam int START_W     = 12;
   localparam int SUM_W       = 32;
   localparam int SLOT_W      = 12;
   localparam int ENTRY_W     = 13;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // Decoupling queue between classifier and list unit
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [1:0] {
      DEC_ACCEPT     = 2'd0,
      DEC_SPLIT_SRC  = 2'd1,
      DEC_SPLIT_SINK = 2'd2
   } decision_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SINK_X         = 3'd0,
      CSR_SINK_Y         = 3'd1,
      CSR_SINK_Z         = 3'd2,
      CSR_SINK_EXTENT    = 3'd3,
      CSR_SINK_IS_BODY   = 3'd4,
      CSR_START_COUNT    = 3'd5,
      CSR_TRAVERSAL_MODE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                         is_cell;
      logic [MASS_W-1:0]            source_mass;
      logic signed [COORD_BITS-1:0] source_x;
      logic signed [COORD_BITS-1:0] source_y;
      logic signed [COORD_BITS-1:0] source_z;
      logic [RADIUS_W-1:0]          source_rcrit;
      logic [DAUGHTER_W-1:0]        source_daughters;
      logic                         last;
   } req_item_type;

   typedef struct packed {
      decision_type       decision;
      logic               list_written;
      logic [SLOT_W-1:0]  list_slot;
      logic               overflow;
      logic               body_split_error;
      logic [SUM_W-1:0]   interaction_total;
      logic [ENTRY_W-1:0] entry_total;
   } rsp_item_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] sink_x;
      logic signed [COORD_BITS-1:0] sink_y;
      logic signed [COORD_BITS-1:0] sink_z;
      logic [RADIUS_W-1:0]          sink_extent;
      logic                         sink_is_body;
      logic [START_W-1:0]           start_count;
      logic                         traversal_mode;
   } sink_cfg_type;

   // Classified word handed from the front to the list unit
   typedef struct packed {
      decision_type decision;
      logic         body_split_error;
      req_item_type src;
   } class_item_type;

endpackage

// ===== rtl/core/tcac_front.sv =====
// Classifier front: distance and radius pipeline plus the acceptance decision.
// Depends on tcac_pkg; feeds the decoupling queue.
module tcac_front (
   input  logic                    clock,
   input  logic                    reset,
   input  tcac_pkg::sink_cfg_type  sink_cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tcac_pkg::req_item_type  req_data,
   output logic                    push_valid,
   input  logic                    push_ready,
   output tcac_pkg::class_item_type push_data
);
   import tcac_pkg::*;

   // stage 1: coordinate differences and summed radius
   logic               s1_valid_ff;
   req_item_type       s1_item_ff;
   logic [MAG_W-1:0]   s1_mag_x_ff, s1_mag_y_ff, s1_mag_z_ff;
   logic [RB_W-1:0]    s1_rb_ff;
   logic               s1_pref_ff;
   // stage 2: squares
   logic               s2_valid_ff;
   req_item_type       s2_item_ff;
   logic [SQ_W-1:0]    s2_sq_x_ff, s2_sq_y_ff, s2_sq_z_ff;
   logic [RB2_W-1:0]   s2_rb2_ff;
   logic [RC2_W-1:0]   s2_rc2_ff;
   logic               s2_pref_ff;
   // stage 3: distance squared
   logic               s3_valid_ff;
   req_item_type       s3_item_ff;
   logic [DR2_W-1:0]   s3_dr2_ff;
   logic [RB2_W-1:0]   s3_rb2_ff;
   logic [RC2_W-1:0]   s3_rc2_ff;
   logic               s3_pref_ff;
   // stage 4: compare results
   logic               s4_valid_ff;
   req_item_type       s4_item_ff;
   logic               s4_gt_rb_ff, s4_lt_rc_ff, s4_pref_ff;

   logic               advance;
   logic [MAG_W-1:0]   s1_mag_x_in, s1_mag_y_in, s1_mag_z_in;
   logic [RB_W-1:0]    s1_rb_in;
   logic               s1_pref_in;
   decision_type       decision;
   logic               split_error;

   function automatic logic [MAG_W-1:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic [DIFF_W-1:0] d;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      if (d[DIFF_W-1]) begin
         d = ~d + DIFF_W'(1);
      end
      return d[MAG_W-1:0];
   endfunction

   // hold the whole pipe while the last stage cannot hand off
   assign advance    = !(s4_valid_ff && !push_ready);
   assign req_ready  = advance;
   assign push_valid = s4_valid_ff;

   always_comb begin
      s1_mag_x_in = abs_diff(req_data.source_x, sink_cfg.sink_x);
      s1_mag_y_in = abs_diff(req_data.source_y, sink_cfg.sink_y);
      s1_mag_z_in = abs_diff(req_data.source_z, sink_cfg.sink_z);
      s1_rb_in    = {1'b0, req_data.source_rcrit} + {1'b0, sink_cfg.sink_extent};
      s1_pref_in  = {sink_cfg.sink_extent, 2'b00} > {1'b0, s1_rb_in};
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff  <= req_data;
         s1_mag_x_ff <= s1_mag_x_in;
         s1_mag_y_ff <= s1_mag_y_in;
         s1_mag_z_ff <= s1_mag_z_in;
         s1_rb_ff    <= s1_rb_in;
         s1_pref_ff  <= s1_pref_in;

         s2_item_ff  <= s1_item_ff;
         s2_sq_x_ff  <= SQ_W'(s1_mag_x_ff) * SQ_W'(s1_mag_x_ff);
         s2_sq_y_ff  <= SQ_W'(s1_mag_y_ff) * SQ_W'(s1_mag_y_ff);
         s2_sq_z_ff  <= SQ_W'(s1_mag_z_ff) * SQ_W'(s1_mag_z_ff);
         s2_rb2_ff   <= RB2_W'(s1_rb_ff) * RB2_W'(s1_rb_ff);
         s2_rc2_ff   <= RC2_W'(s1_item_ff.source_rcrit) * RC2_W'(s1_item_ff.source_rcrit);
         s2_pref_ff  <= s1_pref_ff;

         s3_item_ff  <= s2_item_ff;
         s3_dr2_ff   <= DR2_W'(s2_sq_x_ff) + DR2_W'(s2_sq_y_ff) + DR2_W'(s2_sq_z_ff);
         s3_rb2_ff   <= s2_rb2_ff;
         s3_rc2_ff   <= s2_rc2_ff;
         s3_pref_ff  <= s2_pref_ff;

         s4_item_ff  <= s3_item_ff;
         s4_gt_rb_ff <= s3_dr2_ff > DR2_W'(s3_rb2_ff);
         s4_lt_rc_ff <= s3_dr2_ff < DR2_W'(s3_rc2_ff);
         s4_pref_ff  <= s3_pref_ff;
      end
   end

   // classify: dual rule in mode 0, plain critical radius rule in mode 1
   always_comb begin
      decision    = DEC_ACCEPT;
      split_error = 1'b0;
      if (!sink_cfg.traversal_mode) begin
         if (s4_item_ff.is_cell && !s4_gt_rb_ff) begin
            if (s4_pref_ff) begin
               decision    = DEC_SPLIT_SINK;
               split_error = sink_cfg.sink_is_body;
            end else begin
               decision = DEC_SPLIT_SRC;
            end
         end
      end else begin
         if (!sink_cfg.sink_is_body) begin
            decision = DEC_SPLIT_SINK;
         end else if (s4_item_ff.is_cell && s4_lt_rc_ff) begin
            decision = DEC_SPLIT_SRC;
         end
      end
      push_data.decision         = decision;
      push_data.body_split_error = split_error;
      push_data.src              = s4_item_ff;
   end

endmodule

// ===== rtl/core/tcac_queue.sv =====
// Short first-word-fall-through queue between classifier and list unit.
// Depends on tcac_pkg for the classified word type and depth.
module tcac_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  tcac_pkg::class_item_type push_data,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output tcac_pkg::class_item_type pop_data
);
   import tcac_pkg::*;

   class_item_type      slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != (QPTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/tcac_back.sv =====
// List unit: appends accepted sources, keeps the batch totals, registers the result.
// Depends on tcac_pkg; takes classified words from the decoupling queue.
module tcac_back #(
   parameter int LIST_DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcac_pkg::sink_cfg_type   sink_cfg,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  tcac_pkg::class_item_type pop_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tcac_pkg::rsp_item_type   rsp_data
);
   import tcac_pkg::*;

   localparam int IDX_W  = $clog2(LIST_DEPTH);
   localparam int APP_W  = $clog2(LIST_DEPTH + 1);
   localparam int FILL_W = $clog2(LIST_DEPTH + (1 << START_W));
   localparam int POS_W  = 3 * COORD_BITS;

   // interaction list store, contents undefined until written
   logic [MASS_W-1:0]  mass_mem     [LIST_DEPTH];
   logic [POS_W-1:0]   position_mem [LIST_DEPTH];

   logic [APP_W-1:0]   appended_ff, appended_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   logic               fire;
   logic [FILL_W-1:0]  fill, fill_out;
   logic               full, accept, written;
   logic [SUM_W-1:0]   add_count, sum_new;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // evaluate the head word against the list fill level
   always_comb begin
      fill      = FILL_W'(sink_cfg.start_count) + FILL_W'(appended_ff);
      full      = fill >= FILL_W'(LIST_DEPTH);
      accept    = pop_data.decision == DEC_ACCEPT;
      written   = accept && !full;
      add_count = pop_data.src.is_cell ? SUM_W'(pop_data.src.source_daughters) : SUM_W'(1);
      sum_new   = accept ? sum_ff + add_count : sum_ff;
      fill_out  = written ? fill + FILL_W'(1) : fill;

      rsp_data_in.decision          = pop_data.decision;
      rsp_data_in.list_written      = written;
      rsp_data_in.list_slot         = written ? SLOT_W'(fill) : '0;
      rsp_data_in.overflow          = accept && full;
      rsp_data_in.body_split_error  = pop_data.body_split_error;
      rsp_data_in.interaction_total = sum_new;
      rsp_data_in.entry_total       = ENTRY_W'(fill_out);

      // clear batch counters after the last word
      appended_in  = appended_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (pop_data.src.last) begin
            appended_in = '0;
            sum_in      = '0;
         end else begin
            appended_in = appended_ff + APP_W'(written);
            sum_in      = sum_new;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         appended_ff  <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         appended_ff  <= appended_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // append the accepted source to the list
   always_ff @(posedge clock) begin
      if (fire && written) begin
         mass_mem[fill[IDX_W-1:0]]     <= pop_data.src.source_mass;
         position_mem[fill[IDX_W-1:0]] <= {pop_data.src.source_z, pop_data.src.source_y,
                                           pop_data.src.source_x};
      end
   end

endmodule

// ===== rtl/core/tree_cell_acceptance_classifier_top.sv =====
// Top level of the tree cell acceptance classifier: sink registers and the
// front / queue / list unit chain. Depends on tcac_pkg, tcac_front, tcac_queue, tcac_back.
//
//   port group | dir | handshake        | word
//   req_*      | in  | req_valid/ready  | one tree source (tcac_pkg::req_item_type)
//   rsp_*      | out | rsp_valid/ready  | one decision (tcac_pkg::rsp_item_type)
//   csr_*      | in  | csr_we           | sink register write, index 0..6
//
// One word per clock sustained while rsp is not stalled; a taken word passes the four-stage
// distance pipeline, the queue and the result register before it shows on rsp.
// Reset is synchronous: it clears valid bits, batch counters and sink registers;
// the interaction list store is left as is.
// A stalled rsp fills the four-entry queue, after which the front halts and
// req_ready drops; the list unit reads its fill counter once per word.
module tree_cell_acceptance_classifier_top #(
   parameter int LIST_DEPTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tcac_pkg::req_item_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tcac_pkg::rsp_item_type             rsp_data,
   input  logic                               csr_we,
   input  logic [tcac_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tcac_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tcac_pkg::*;

   sink_cfg_type   cfg_ff, cfg_in;
   logic           q_push_valid, q_push_ready;
   class_item_type q_push_data;
   logic           q_pop_valid, q_pop_ready;
   class_item_type q_pop_data;

   // decode sink register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SINK_X:         cfg_in.sink_x         = csr_wdata[COORD_BITS-1:0];
            CSR_SINK_Y:         cfg_in.sink_y         = csr_wdata[COORD_BITS-1:0];
            CSR_SINK_Z:         cfg_in.sink_z         = csr_wdata[COORD_BITS-1:0];
            CSR_SINK_EXTENT:    cfg_in.sink_extent    = csr_wdata[RADIUS_W-1:0];
            CSR_SINK_IS_BODY:   cfg_in.sink_is_body   = csr_wdata[0];
            CSR_START_COUNT:    cfg_in.start_count    = csr_wdata[START_W-1:0];
            CSR_TRAVERSAL_MODE: cfg_in.traversal_mode = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .sink_cfg   (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data)
   );

   tcac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   tcac_back #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .sink_cfg   (cfg_ff),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // an append only follows an accept that found room
   a_written_is_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.list_written |->
         rsp_data.decision == DEC_ACCEPT && !rsp_data.overflow)
      else $error("list append without a plain accept");

   // the body split flag only goes with a sink split
   a_error_is_sink_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.body_split_error |-> rsp_data.decision == DEC_SPLIT_SINK)
      else $error("body split error without sink split");

   // a word popped from the queue reaches the result register
   a_queue_pop_has_word: assert property (@(posedge clock) disable iff (reset)
      q_pop_ready && q_pop_valid |=> rsp_valid)
      else $error("popped word did not reach the result register");

   // nothing is shown right after reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

// ===== sim/tb_tree_cell_acceptance_classifier_top.sv =====
`timescale 1ns / 100ps
// Testbench for tree_cell_acceptance_classifier_top: directed table, then random sink phases,
// every decision word checked against its table entry or an in-bench model of the acceptance test and list fill.
// Depends on tcac_pkg and the block's RTL only.
module tb_tree_cell_acceptance_classifier_top;
   import tcac_pkg::*;

   localparam int LIST_DEPTH     = 4096;
   localparam int SPLIT_FACTOR   = 4;
   localparam int MAX_IDLE       = 11;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 12;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   typedef struct {
      logic         setup;
      sink_cfg_type cfg;
      req_item_type src;
      logic         typed;
      rsp_item_type rsp;
   } directed_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_item_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_item_type           rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Model state: sink registers and the batch counters
   sink_cfg_type       sink_cfg           = '0;
   logic [ENTRY_W-1:0] batch_appended     = '0;
   logic [SUM_W-1:0]   batch_interactions = '0;

   rsp_item_type     pending_decisions[$];
   directed_row_type directed_rows[$];
   int               mismatch_count  = 0;
   bit               send_idle       = 1'b0;
   bit               recv_idle       = 1'b0;
   int               rsp_hold_cycles = 0;
   int               stalled_cycles  = 0;
   int unsigned      span_bits       = 8;
   logic [31:0]      phase_center    = '0;

   tree_cell_acceptance_classifier_top #(.LIST_DEPTH(LIST_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Exact squared gap along one axis
   function automatic logic [127:0] axis_gap_sq(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b);
      longint       gap;
      logic [127:0] mag;
      gap = longint'($signed(a)) - longint'($signed(b));
      mag = (gap < 0) ? 128'(-gap) : 128'(gap);
      return mag * mag;
   endfunction

   // Classify one source against the sink and advance the list fill and totals
   function automatic rsp_item_type classify_source(input req_item_type src);
      rsp_item_type     out;
      logic [127:0]     dist_sq;
      logic [127:0]     reach;
      logic [127:0]     reach_sq;
      logic [127:0]     rcrit_sq;
      logic [ENTRY_W:0] fill;
      out      = '0;
      dist_sq  = axis_gap_sq(src.source_x, sink_cfg.sink_x)
               + axis_gap_sq(src.source_y, sink_cfg.sink_y)
               + axis_gap_sq(src.source_z, sink_cfg.sink_z);
      reach    = 128'(src.source_rcrit) + 128'(sink_cfg.sink_extent);
      reach_sq = reach * reach;
      rcrit_sq = 128'(src.source_rcrit) * 128'(src.source_rcrit);
      fill     = sink_cfg.start_count + batch_appended;
      out.decision = DEC_ACCEPT;

      if (!sink_cfg.traversal_mode) begin
         // dual rule: bodies always pass, cells test against rcrit + bmax
         if (src.is_cell && !(dist_sq > reach_sq)) begin
            if (128'(sink_cfg.sink_extent) * SPLIT_FACTOR > reach) begin
               out.decision         = DEC_SPLIT_SINK;
               out.body_split_error = sink_cfg.sink_is_body;
            end else begin
               out.decision = DEC_SPLIT_SRC;
            end
         end
      end else if (!sink_cfg.sink_is_body) begin
         out.decision = DEC_SPLIT_SINK;
      end else if (src.is_cell && dist_sq < rcrit_sq) begin
         out.decision = DEC_SPLIT_SRC;
      end

      // Append on accept unless the list is full; interactions count either way
      if (out.decision == DEC_ACCEPT) begin
         if (fill >= LIST_DEPTH) begin
            out.overflow = 1'b1;
         end else begin
            out.list_written = 1'b1;
            out.list_slot    = fill[SLOT_W-1:0];
            batch_appended++;
            fill++;
         end
         batch_interactions += src.is_cell ? SUM_W'(src.source_daughters) : SUM_W'(1);
      end
      out.interaction_total = batch_interactions;
      out.entry_total       = fill[ENTRY_W-1:0];

      // Clear the batch after its last word
      if (src.last) begin
         batch_appended     = '0;
         batch_interactions = '0;
      end
      return out;
   endfunction

   function automatic req_item_type mk_src(input logic is_cell, input logic [MASS_W-1:0] mass,
         input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
         input logic [COORD_BITS-1:0] z, input logic [RADIUS_W-1:0] rcrit,
         input logic [DAUGHTER_W-1:0] daughters, input logic last);
      req_item_type src;
      src.is_cell          = is_cell;
      src.source_mass      = mass;
      src.source_x         = x;
      src.source_y         = y;
      src.source_z         = z;
      src.source_rcrit     = rcrit;
      src.source_daughters = daughters;
      src.last             = last;
      return src;
   endfunction

   function automatic rsp_item_type mk_rsp(input decision_type decision, input logic written,
         input logic [SLOT_W-1:0] slot, input logic overflow, input logic split_error,
         input logic [SUM_W-1:0] total, input logic [ENTRY_W-1:0] entries);
      rsp_item_type rsp;
      rsp.decision          = decision;
      rsp.list_written      = written;
      rsp.list_slot         = slot;
      rsp.overflow          = overflow;
      rsp.body_split_error  = split_error;
      rsp.interaction_total = total;
      rsp.entry_total       = entries;
      return rsp;
   endfunction

   function automatic sink_cfg_type mk_sink(input logic [COORD_BITS-1:0] x,
         input logic [COORD_BITS-1:0] y, input logic [COORD_BITS-1:0] z,
         input logic [RADIUS_W-1:0] extent, input logic is_body,
         input logic [START_W-1:0] start, input logic mode);
      sink_cfg_type cfg;
      cfg.sink_x         = x;
      cfg.sink_y         = y;
      cfg.sink_z         = z;
      cfg.sink_extent    = extent;
      cfg.sink_is_body   = is_body;
      cfg.start_count    = start;
      cfg.traversal_mode = mode;
      return cfg;
   endfunction

   function automatic void add_row(input logic setup, input sink_cfg_type cfg,
         input req_item_type src, input logic typed, input rsp_item_type rsp);
      directed_row_type row;
      row.setup = setup;
      row.cfg   = cfg;
      row.src   = src;
      row.typed = typed;
      row.rsp   = rsp;
      directed_rows.push_back(row);
   endfunction

   // Random value within +/- 2^span_bits of the phase center, wrapping at 32 bits
   function automatic logic [31:0] near_center();
      logic [31:0] offset;
      offset = $urandom & ((32'd2 << span_bits) - 1);
      return phase_center + offset - (32'd1 << span_bits);
   endfunction

   function automatic sink_cfg_type random_sink();
      sink_cfg_type cfg;
      cfg.sink_x = near_center();
      cfg.sink_y = near_center();
      cfg.sink_z = near_center();
      case ($urandom_range(0, 3))
         0:       cfg.sink_extent = '0;
         1:       cfg.sink_extent = RADIUS_W'($urandom);
         default: cfg.sink_extent = RADIUS_W'($urandom & ((32'd2 << span_bits) - 1));
      endcase
      case ($urandom_range(0, 3))
         0:       cfg.start_count = '0;
         1:       cfg.start_count = '1;
         2:       cfg.start_count = START_W'(LIST_DEPTH - $urandom_range(1, 40));
         default: cfg.start_count = START_W'($urandom);
      endcase
      cfg.sink_is_body   = 1'($urandom_range(0, 1));
      cfg.traversal_mode = 1'($urandom_range(0, 1));
      return cfg;
   endfunction

   function automatic req_item_type random_source();
      req_item_type src;
      bit           wide;
      wide                 = ($urandom_range(0, 9) == 0);
      src.is_cell          = ($urandom_range(0, 3) != 0);
      src.source_mass      = $urandom;
      src.source_x         = wide ? $urandom : near_center();
      src.source_y         = wide ? $urandom : near_center();
      src.source_z         = wide ? $urandom : near_center();
      src.source_rcrit     = wide ? RADIUS_W'($urandom)
                                  : RADIUS_W'($urandom & ((32'd4 << span_bits) - 1));
      src.source_daughters = DAUGHTER_W'($urandom);
      src.last             = ($urandom_range(0, 15) == 0);
      return src;
   endfunction

   // Report one field; returns 1 on mismatch
   function automatic bit field_differs(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void check_decision(input rsp_item_type got);
      rsp_item_type want;
      bit           bad;
      if (pending_decisions.size() == 0) begin
         $display("%0t ns: result word expected none got %h", $time, got);
         mismatch_count++;
         return;
      end
      want = pending_decisions.pop_front();
      bad  = field_differs("decision", want.decision, got.decision)
           | field_differs("list_written", want.list_written, got.list_written)
           | field_differs("list_slot", want.list_slot, got.list_slot)
           | field_differs("overflow", want.overflow, got.overflow)
           | field_differs("body_split_error", want.body_split_error, got.body_split_error)
           | field_differs("interaction_total", want.interaction_total, got.interaction_total)
           | field_differs("entry_total", want.entry_total, got.entry_total);
      if (bad)
         mismatch_count++;
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] reg_index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= data;
   endtask

   // Write every sink register, with junk in the unused upper bits, then the spare index
   task automatic load_sink(input sink_cfg_type cfg);
      csr_write(CSR_SINK_X, cfg.sink_x);
      csr_write(CSR_SINK_Y, cfg.sink_y);
      csr_write(CSR_SINK_Z, cfg.sink_z);
      csr_write(CSR_SINK_EXTENT, {1'($urandom), cfg.sink_extent});
      csr_write(CSR_SINK_IS_BODY, {31'($urandom), cfg.sink_is_body});
      csr_write(CSR_START_COUNT, {20'($urandom), cfg.start_count});
      csr_write(CSR_TRAVERSAL_MODE, {31'($urandom), cfg.traversal_mode});
      csr_write(CSR_SPARE_INDEX, $urandom);
      @(negedge clock);
      csr_we   <= 1'b0;
      sink_cfg  = cfg;
   endtask

   // Drop valid and hold until every expected word is back and the pipe is empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_decisions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offer one source word; record its expected decision once taken
   task automatic push_source(input req_item_type src, input logic typed = 1'b0,
                              input rsp_item_type typed_rsp = '0);
      int           gap;
      rsp_item_type want;
      gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= src;
      do @(posedge clock); while (!req_ready);
      want = classify_source(src);
      pending_decisions.push_back(typed ? typed_rsp : want);
      @(negedge clock);
   endtask

   // Stimulus: directed table, then random phases
   initial begin
      sink_cfg_type cfg;
      int           n_items;

      // Reset sink: origin, zero extent, cell sink, empty list, dual rule
      add_row(1'b0, '0, mk_src(1'b0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1'b0),
              1'b1, mk_rsp(DEC_ACCEPT, 1'b1, 0, 1'b0, 1'b0, 1, 1));
      add_row(1'b0, '0, mk_src(1'b1, 0, 0, 0, 0, 0, 5, 1'b0),
              1'b1, mk_rsp(DEC_SPLIT_SRC, 1'b0, 0, 1'b0, 1'b0, 1, 1));
      add_row(1'b0, '0, mk_src(1'b1, 32'h1234_5678, 1, 0, 0, 0, 21'h10_0000, 1'b0),
              1'b1, mk_rsp(DEC_ACCEPT, 1'b1, 1, 1'b0, 1'b0, 32'h10_0001, 2));
      // zero daughters add nothing
      add_row(1'b0, '0, mk_src(1'b1, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              31'h7FFF_FFFF, 0, 1'b0),
              1'b1, mk_rsp(DEC_ACCEPT, 1'b1, 2, 1'b0, 1'b0, 32'h10_0001, 3));
      add_row(1'b0, '0, mk_src(1'b1, 32'hAAAA_5555, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 31'h7FFF_FFFF, 21'h1F_FFFF, 1'b1),
              1'b1, mk_rsp(DEC_ACCEPT, 1'b1, 3, 1'b0, 1'b0, 32'h30_0000, 4));

      // Body sink with extent, list nearly full: split-sink error, boundaries, overflow
      cfg = mk_sink(0, 0, 0, 100, 1'b1, 4094, 1'b0);
      add_row(1'b1, cfg, mk_src(1'b1, 32'h5555_AAAA, 10, 0, 0, 50, 3, 1'b0),
              1'b1, mk_rsp(DEC_SPLIT_SINK, 1'b0, 0, 1'b0, 1'b1, 0, 4094));
      add_row(1'b0, cfg, mk_src(1'b1, 0, 150, 0, 0, 50, 3, 1'b0),
              1'b1, mk_rsp(DEC_SPLIT_SINK, 1'b0, 0, 1'b0, 1'b1, 0, 4094));
      add_row(1'b0, cfg, mk_src(1'b1, 0, 10, 0, 0, 300, 3, 1'b0),
              1'b1, mk_rsp(DEC_SPLIT_SRC, 1'b0, 0, 1'b0, 1'b0, 0, 4094));
      add_row(1'b0, cfg, mk_src(1'b0, 1, 5, 5, 5, 0, 0, 1'b0),
              1'b1, mk_rsp(DEC_ACCEPT, 1'b1, 4094, 1'b0, 1'b0, 1, 4095));
      add_row(1'b0, cfg, mk_src(1'b0, 2, -5, -5, -5, 0, 0, 1'b0),
              1'b1, mk_rsp(DEC_ACCEPT, 1'b1, 4095, 1'b0, 1'b0, 2, 4096));
      add_row(1'b0, cfg, mk_src(1'b0, 3, 0, 0, 0, 0, 0, 1'b0),
              1'b1, mk_rsp(DEC_ACCEPT, 1'b0, 0, 1'b1, 1'b0, 3, 4096));
      add_row(1'b0, cfg, mk_src(1'b1, 4, 1000000, 0, 0, 1, 7, 1'b1),
              1'b1, mk_rsp(DEC_ACCEPT, 1'b0, 0, 1'b1, 1'b0, 10, 4096));
      add_row(1'b0, cfg, mk_src(1'b0, 5, 0, 0, 0, 0, 0, 1'b0),
              1'b1, mk_rsp(DEC_ACCEPT, 1'b1, 4094, 1'b0, 1'b0, 1, 4095));

      // Simple rule with a cell sink: everything splits the sink
      cfg = mk_sink(-5, 7, -9, 31'h7FFF_FFFF, 1'b0, 0, 1'b1);
      add_row(1'b1, cfg, mk_src(1'b0, 6, 1, 2, 3, 0, 0, 1'b0), 1'b0, '0);
      add_row(1'b0, cfg, mk_src(1'b1, 7, -5, 7, -9, 31'h7FFF_FFFF, 9, 1'b0), 1'b0, '0);

      // Simple rule with a body sink: equality accepts
      cfg = mk_sink(100, 0, 0, 0, 1'b1, 0, 1'b1);
      add_row(1'b1, cfg, mk_src(1'b1, 8, 103, 4, 0, 5, 11, 1'b0), 1'b0, '0);
      add_row(1'b0, cfg, mk_src(1'b1, 9, 103, 4, 0, 6, 11, 1'b0), 1'b0, '0);
      add_row(1'b0, cfg, mk_src(1'b0, 10, -2000000000, 2000000000, 0, 0, 0, 1'b0), 1'b0, '0);
      add_row(1'b0, cfg, mk_src(1'b1, 11, 100, 0, 0, 0, 1, 1'b1), 1'b0, '0);

      // Extreme sink corner, maximal extent, last free slot
      cfg = mk_sink(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0,
                    12'hFFF, 1'b0);
      add_row(1'b1, cfg, mk_src(1'b1, 12, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              31'h7FFF_FFFF, 21'h0A_BCDE, 1'b0), 1'b0, '0);
      add_row(1'b0, cfg, mk_src(1'b1, 13, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              0, 2, 1'b0), 1'b0, '0);
      add_row(1'b0, cfg, mk_src(1'b1, 14, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              31'h7FFF_FFFF, 2, 1'b1), 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].setup) begin
            wait_drained();
            load_sink(directed_rows[i].cfg);
            send_idle = 1'($urandom_range(0, 1));
            recv_idle = 1'($urandom_range(0, 1));
         end
         push_source(directed_rows[i].src, directed_rows[i].typed, directed_rows[i].rsp);
      end

      // Random phases, each with its own sink and locality scale
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         span_bits    = $urandom_range(2, 30);
         phase_center = $urandom;
         cfg          = random_sink();
         if (phase == 0) begin
            phase_center       = 32'h8000_0000;
            cfg.sink_x         = 32'h8000_0000;
            cfg.sink_y         = 32'h8000_0000;
            cfg.sink_z         = 32'h8000_0000;
            cfg.sink_extent    = '1;
            cfg.sink_is_body   = 1'b1;
            cfg.start_count    = '1;
            cfg.traversal_mode = 1'b0;
         end else if (phase == 1) begin
            phase_center       = 32'h7FFF_FFFF;
            cfg.sink_x         = 32'h7FFF_FFFF;
            cfg.sink_y         = 32'h7FFF_FFFF;
            cfg.sink_z         = 32'h7FFF_FFFF;
            cfg.sink_extent    = '0;
            cfg.sink_is_body   = 1'b1;
            cfg.start_count    = '0;
            cfg.traversal_mode = 1'b1;
         end
         load_sink(cfg);
         send_idle = ($urandom_range(0, 2) != 0);
         recv_idle = ($urandom_range(0, 2) != 0);
         // Back-pressure run: receiver holds off while the sender streams
         if (phase == 3 || phase == 12) begin
            send_idle       = 1'b0;
            rsp_hold_cycles = LONG_HOLD;
         end
         n_items = $urandom_range(60, 110);
         repeat (n_items) push_source(random_source());
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Result side: stall at random, check each word taken
   initial begin
      int stall;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_decision(rsp_data);
         @(negedge clock);
      end
   end

   // Watchdog: end the run when no word moves for too long
   initial begin
      while (stalled_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled_cycles = 0;
         else
            stalled_cycles++;
      end
      $display("status: fail");
      $finish;
   end

endmodule
